FILE: rtl/swos_pkg.sv
// ============================================================================
// swos_pkg
// Shared widths, operation codes and status codes of the stack with
// occurrence search.
// ============================================================================
package swos_pkg;

    localparam int STACK_DEPTH_DEF = 64;
    localparam int OP_W            = 2;
    localparam int VALUE_W         = 32;
    localparam int STATUS_W        = 2;
    localparam int CNT_W           = 7;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_SEARCH = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

endpackage

FILE: rtl/swos_if.sv
// ============================================================================
// swos_if
// Valid/ready channels of the stack: one command channel and one response
// channel, each with a source and a sink side.
// ============================================================================
interface swos_cmd_if import swos_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           operation;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface

interface swos_rsp_if import swos_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                found;
    logic [CNT_W-1:0]    match_count;
    logic [CNT_W-1:0]    occupancy;

    modport source (output valid, output status, output found, output match_count,
                    output occupancy, input ready);
    modport sink   (input valid, input status, input found, input match_count,
                    input occupancy, output ready);
endinterface

FILE: rtl/swos_mem.sv
// ============================================================================
// swos_mem
// Entry store: one write port, one read port, read data registered.
// ============================================================================
module swos_mem
    import swos_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    localparam int ADDR_W     = $clog2(STACK_DEPTH)
)
(
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [ADDR_W-1:0]         wr_addr,
    input  logic signed [VALUE_W-1:0] wr_data,
    input  logic                      rd_en,
    input  logic [ADDR_W-1:0]         rd_addr,
    output logic signed [VALUE_W-1:0] rd_data
);

    logic signed [VALUE_W-1:0] mem [STACK_DEPTH];
    logic signed [VALUE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/swos_seq.sv
// ============================================================================
// swos_seq
// Sequencer: fill level, push/pop handling, search scan over the entry store
// and the response register.
// ============================================================================
module swos_seq
    import swos_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    localparam int ADDR_W     = $clog2(STACK_DEPTH),
    localparam int LVL_W      = $clog2(STACK_DEPTH + 1)
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    swos_cmd_if.sink                  cmd,
    swos_rsp_if.source                rsp,
    output logic                      wr_en,
    output logic [ADDR_W-1:0]         wr_addr,
    output logic signed [VALUE_W-1:0] wr_data,
    output logic                      rd_en,
    output logic [ADDR_W-1:0]         rd_addr,
    input  logic signed [VALUE_W-1:0] rd_data
);

    localparam logic [LVL_W-1:0] FULL_LVL = LVL_W'(STACK_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } state_t;

    state_t                    state_reg,      state_next;
    logic [LVL_W-1:0]          fill_reg,       fill_next;
    logic [LVL_W-1:0]          issue_reg,      issue_next;
    logic                      pend_reg,       pend_next;
    logic [LVL_W-1:0]          count_reg,      count_next;
    logic signed [VALUE_W-1:0] key_reg,        key_next;
    logic                      res_valid_reg,  res_valid_next;
    logic [STATUS_W-1:0]       res_status_reg, res_status_next;
    logic                      res_found_reg,  res_found_next;
    logic [CNT_W-1:0]          res_count_reg,  res_count_next;
    logic [CNT_W-1:0]          res_occ_reg,    res_occ_next;
    logic                      take;
    logic                      match;

    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        issue_next      = issue_reg;
        pend_next       = pend_reg;
        count_next      = count_reg;
        key_next        = key_reg;
        res_valid_next  = res_valid_reg;
        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;
        res_count_next  = res_count_reg;
        res_occ_next    = res_occ_reg;
        wr_en           = 1'b0;
        wr_addr         = fill_reg[ADDR_W-1:0];
        wr_data         = cmd.value;
        rd_en           = 1'b0;
        rd_addr         = issue_reg[ADDR_W-1:0];
        cmd.ready       = 1'b0;
        take            = 1'b0;
        match           = pend_reg && (rd_data == key_reg);

        // drop the response once the sink has taken it
        if (rsp.valid && rsp.ready)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                cmd.ready = !res_valid_reg || rsp.ready;
                take      = cmd.valid && cmd.ready;
                if (take)
                begin
                    res_valid_next  = 1'b1;
                    res_status_next = ST_OK;
                    res_found_next  = 1'b0;
                    res_count_next  = '0;
                    case (cmd.operation)
                        OP_PUSH:
                        begin
                            if (fill_reg == FULL_LVL)
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                wr_en     = 1'b1;
                                fill_next = fill_reg + LVL_W'(1);
                            end
                        end
                        OP_POP:
                        begin
                            if (fill_reg == '0)
                            begin
                                res_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                fill_next = fill_reg - LVL_W'(1);
                            end
                        end
                        OP_SEARCH:
                        begin
                            if (fill_reg == '0)
                            begin
                                res_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                // hold the response until the scan ends
                                res_valid_next = 1'b0;
                                key_next       = cmd.value;
                                issue_next     = '0;
                                pend_next      = 1'b0;
                                count_next     = '0;
                                state_next     = S_SCAN;
                            end
                        end
                        default:
                        begin
                            res_status_next = ST_OK;
                        end
                    endcase
                    res_occ_next = CNT_W'(fill_next);
                end
            end
            S_SCAN:
            begin
                // issue one read a cycle, compare the word that comes back
                rd_en     = (issue_reg != fill_reg);
                pend_next = rd_en;
                if (rd_en)
                begin
                    issue_next = issue_reg + LVL_W'(1);
                end
                if (match)
                begin
                    count_next = count_reg + LVL_W'(1);
                end
                if (!rd_en && pend_reg)
                begin
                    res_valid_next  = 1'b1;
                    res_status_next = ST_OK;
                    res_found_next  = (count_next != '0);
                    res_count_next  = CNT_W'(count_next);
                    res_occ_next    = CNT_W'(fill_reg);
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            issue_reg     <= '0;
            pend_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            issue_reg     <= issue_next;
            pend_reg      <= pend_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        count_reg      <= count_next;
        key_reg        <= key_next;
        res_status_reg <= res_status_next;
        res_found_reg  <= res_found_next;
        res_count_reg  <= res_count_next;
        res_occ_reg    <= res_occ_next;
    end

    assign rsp.valid       = res_valid_reg;
    assign rsp.status      = res_status_reg;
    assign rsp.found       = res_found_reg;
    assign rsp.match_count = res_count_reg;
    assign rsp.occupancy   = res_occ_reg;

endmodule

FILE: rtl/stack_with_occurrence_search_unit.sv
// ============================================================================
// stack_with_occurrence_search_unit
// Bounded LIFO stack of signed 32-bit words with push, pop and an occurrence
// search that counts stored entries equal to a key.
// ============================================================================
// Each command transaction carries one operation and produces exactly one
// response transaction with status, found flag, match count and the occupancy
// after the operation. Push and pop complete in the accepting cycle, and their
// response is registered: valid in the cycle after the command is accepted. A
// search accepts the command, then sweeps the single read port of the entry
// store from the bottom entry up, one word a cycle, while the read data of the
// previous cycle is compared, and last compares the top word; its response is
// then registered. Push on a full stack is dropped with status full; pop or
// search on an empty stack report status empty; operation code 3 is ignored
// with status ok. A finished response sits in an output register, and the next
// command is taken in the same cycle that the response transaction completes.
// Writes (push) and reads (search) never overlap, so no forwarding is needed.
// Counts and occupancy are reported modulo 128 when STACK_DEPTH is above 127.
// ============================================================================
module stack_with_occurrence_search_unit
    import swos_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    swos_cmd_if.sink   cmd,
    swos_rsp_if.source rsp
);

    localparam int ADDR_W = $clog2(STACK_DEPTH);

    // store port signals between sequencer and entry store
    logic                      wr_en;
    logic [ADDR_W-1:0]         wr_addr;
    logic signed [VALUE_W-1:0] wr_data;
    logic                      rd_en;
    logic [ADDR_W-1:0]         rd_addr;
    logic signed [VALUE_W-1:0] rd_data;

    // sequencer: fill level, scan and the response register
    swos_seq #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .rsp     (rsp),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // entry store, one word per stack slot
    swos_mem #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

FILE: tb/testbench.sv
// ============================================================================
// testbench
// Self-checking bench for the LIFO stack with occurrence search. A directed
// table covers the corners (empty, extremes, duplicate keys, ignored code),
// then random fill, drain and mixed episodes run against a built-in stack
// predictor while both channels idle and stall at random.
// ============================================================================
module testbench;
    import swos_pkg::*;

    localparam int STACK_DEPTH = STACK_DEPTH_DEF;
    localparam int ITEM_TARGET = 1250;    // counted commands, ignored code excluded
    localparam int DRAIN_WAIT  = 80;      // cycles after the last response
    localparam int DIR_ROWS    = 24;

    // Code 3 is outside the enum; the block must treat it as a no-op.
    localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;

    typedef struct packed {
        status_t          status;
        logic             found;
        logic [CNT_W-1:0] match_count;
        logic [CNT_W-1:0] occupancy;
    } outcome_t;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [VALUE_W-1:0] operand;
        logic               pinned;     // use the typed outcome below
        outcome_t           want;
    } dir_row_t;

    typedef enum int {RX_ALWAYS, RX_COIN, RX_PATTERN, RX_SPARSE} stall_mode_t;

    logic clk;
    logic rst_n;

    swos_cmd_if cmd_ch ();
    swos_rsp_if rsp_ch ();

    stack_with_occurrence_search_unit #(
        .STACK_DEPTH (STACK_DEPTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    // ------------------------------------------------------------------------
    // Clock: period of 10 units
    // ------------------------------------------------------------------------
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Predictor state: a private copy of the stack
    // ------------------------------------------------------------------------
    logic [VALUE_W-1:0] model_entries [STACK_DEPTH];
    int unsigned        model_fill = 0;

    outcome_t pending_outcomes [$];
    int       mismatch_count = 0;

    // Coverage tallies for the closing summary
    int unsigned op_tally [4] = '{0, 0, 0, 0};
    int unsigned full_drops   = 0;
    int unsigned empty_hits   = 0;
    int unsigned search_hits  = 0;
    int unsigned peak_matches = 0;
    int unsigned items_counted = 0;

    // Sender burst control and key pool for random content
    int unsigned        burst_left = 25;
    logic [VALUE_W-1:0] key_pool [8];
    int unsigned        pool_size  = 1;
    int unsigned        noise_pct  = 15;

    dir_row_t directed_rows [DIR_ROWS];

    // Apply one command to the private stack and return the response it
    // should produce. Only positions below the fill level are ever read.
    function automatic outcome_t stack_outcome(input logic [OP_W-1:0]    op,
                                               input logic [VALUE_W-1:0] operand);
        outcome_t    res;
        int unsigned hits;
        res  = '{ST_OK, 1'b0, '0, '0};
        hits = 0;
        case (op)
            OP_PUSH:
            begin
                if (model_fill >= STACK_DEPTH)
                begin
                    res.status = ST_FULL;
                end
                else
                begin
                    model_entries[model_fill] = operand;
                    model_fill++;
                end
            end
            OP_POP:
            begin
                if (model_fill == 0)
                    res.status = ST_EMPTY;
                else
                    model_fill--;
            end
            OP_SEARCH:
            begin
                if (model_fill == 0)
                begin
                    res.status = ST_EMPTY;
                end
                else
                begin
                    for (int i = 0; i < model_fill; i++)
                        if (model_entries[i] == operand)
                            hits++;
                    res.found       = (hits != 0);
                    res.match_count = CNT_W'(hits);
                end
            end
            default:
            begin
                // ignored code: stack untouched, status ok
            end
        endcase
        res.occupancy = CNT_W'(model_fill);
        return res;
    endfunction

    // Mostly keys from the current pool so searches hit, with some noise.
    function automatic logic [VALUE_W-1:0] pick_value();
        if ($urandom_range(0, 99) < noise_pct)
            return $urandom();
        return key_pool[$urandom_range(0, pool_size - 1)];
    endfunction

    // Drive one command transaction, hold it until accepted, record the
    // expected response, then either carry on the burst or drop valid for a gap.
    task automatic send_command(input logic [OP_W-1:0]    op,
                                input logic [VALUE_W-1:0] operand,
                                input logic               pinned,
                                input outcome_t           pinned_outcome);
        outcome_t    predicted;
        int unsigned gap;
        cmd_ch.valid     <= 1'b1;
        cmd_ch.operation <= op;
        cmd_ch.value     <= operand;
        do
            @(posedge clk);
        while (!cmd_ch.ready);

        predicted = stack_outcome(op, operand);
        pending_outcomes.push_back(pinned ? pinned_outcome : predicted);

        op_tally[op]++;
        if (op != OP_IGNORED)
            items_counted++;
        if (predicted.status == ST_FULL)
            full_drops++;
        if (predicted.status == ST_EMPTY)
            empty_hits++;
        if (predicted.found)
            search_hits++;
        if (predicted.match_count > peak_matches)
            peak_matches = predicted.match_count;

        burst_left--;
        if (burst_left == 0)
        begin
            // Drop valid and scramble the payload while idle.
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 80)
                                              : $urandom_range(1, 6);
            cmd_ch.valid     <= 1'b0;
            cmd_ch.operation <= OP_W'($urandom());
            cmd_ch.value     <= $urandom();
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 40);
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus: reset, directed table, random episodes, drain and verdict
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int unsigned episode;
        int unsigned roll;
        logic [OP_W-1:0] op;

        rst_n            <= 1'b0;
        cmd_ch.valid     <= 1'b0;
        cmd_ch.operation <= OP_PUSH;
        cmd_ch.value     <= '0;

        // Stack after rows 4-8, bottom to top:
        //   8000_0000, 7fff_ffff, 0000_0000, ffff_ffff, 7fff_ffff
        directed_rows = '{
            '{OP_POP,     32'h0000_0000, 1'b1, '{ST_EMPTY, 1'b0, 7'd0, 7'd0}},
            '{OP_SEARCH,  32'h0000_0000, 1'b1, '{ST_EMPTY, 1'b0, 7'd0, 7'd0}},
            '{OP_IGNORED, 32'hffff_ffff, 1'b1, '{ST_OK,    1'b0, 7'd0, 7'd0}},
            '{OP_PUSH,    32'h8000_0000, 1'b1, '{ST_OK,    1'b0, 7'd0, 7'd1}},
            '{OP_PUSH,    32'h7fff_ffff, 1'b1, '{ST_OK,    1'b0, 7'd0, 7'd2}},
            '{OP_PUSH,    32'h0000_0000, 1'b1, '{ST_OK,    1'b0, 7'd0, 7'd3}},
            '{OP_PUSH,    32'hffff_ffff, 1'b1, '{ST_OK,    1'b0, 7'd0, 7'd4}},
            '{OP_PUSH,    32'h7fff_ffff, 1'b1, '{ST_OK,    1'b0, 7'd0, 7'd5}},
            '{OP_SEARCH,  32'h7fff_ffff, 1'b1, '{ST_OK,    1'b1, 7'd2, 7'd5}},
            '{OP_SEARCH,  32'h8000_0000, 1'b1, '{ST_OK,    1'b1, 7'd1, 7'd5}},
            '{OP_SEARCH,  32'h0000_0001, 1'b1, '{ST_OK,    1'b0, 7'd0, 7'd5}},
            '{OP_SEARCH,  32'hffff_ffff, 1'b1, '{ST_OK,    1'b1, 7'd1, 7'd5}},
            '{OP_IGNORED, 32'haaaa_5555, 1'b1, '{ST_OK,    1'b0, 7'd0, 7'd5}},
            '{OP_POP,     32'h5555_aaaa, 1'b1, '{ST_OK,    1'b0, 7'd0, 7'd4}},
            '{OP_SEARCH,  32'h7fff_ffff, 1'b1, '{ST_OK,    1'b1, 7'd1, 7'd4}},
            '{OP_PUSH,    32'h5555_aaaa, 1'b0, '0},
            '{OP_SEARCH,  32'h5555_aaaa, 1'b0, '0},
            '{OP_POP,     32'h0000_0000, 1'b1, '{ST_OK,    1'b0, 7'd0, 7'd4}},
            '{OP_POP,     32'h0000_0000, 1'b1, '{ST_OK,    1'b0, 7'd0, 7'd3}},
            '{OP_POP,     32'h0000_0000, 1'b1, '{ST_OK,    1'b0, 7'd0, 7'd2}},
            '{OP_POP,     32'h0000_0000, 1'b1, '{ST_OK,    1'b0, 7'd0, 7'd1}},
            '{OP_POP,     32'h0000_0000, 1'b1, '{ST_OK,    1'b0, 7'd0, 7'd0}},
            '{OP_POP,     32'hffff_ffff, 1'b1, '{ST_EMPTY, 1'b0, 7'd0, 7'd0}},
            '{OP_SEARCH,  32'h0000_0000, 1'b1, '{ST_EMPTY, 1'b0, 7'd0, 7'd0}}
        };

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_command(directed_rows[i].op, directed_rows[i].operand,
                         directed_rows[i].pinned, directed_rows[i].want);

        // Random episodes. The first fill uses one key only, so a search on
        // the full stack counts every entry; the first drain follows it.
        episode = 0;
        while (items_counted < ITEM_TARGET)
        begin
            if (episode == 0)
            begin
                pool_size = 1;
                noise_pct = 0;
            end
            else
            begin
                pool_size = $urandom_range(1, 8);
                noise_pct = 15;
            end
            foreach (key_pool[k])
            begin
                case ($urandom_range(0, 9))
                    0:       key_pool[k] = 32'h8000_0000;
                    1:       key_pool[k] = 32'h7fff_ffff;
                    2:       key_pool[k] = 32'h0000_0000;
                    3:       key_pool[k] = 32'hffff_ffff;
                    default: key_pool[k] = $urandom();
                endcase
            end

            roll = (episode < 2) ? episode : $urandom_range(0, 3);
            case (roll)
                0:
                begin
                    // Fill to the top, then push into the full stack.
                    while (model_fill < STACK_DEPTH)
                    begin
                        if ($urandom_range(0, 4) == 0)
                            send_command(OP_SEARCH, pick_value(), 1'b0, '0);
                        else
                            send_command(OP_PUSH, pick_value(), 1'b0, '0);
                    end
                    send_command(OP_SEARCH, key_pool[0], 1'b0, '0);
                    repeat ($urandom_range(1, 3))
                        send_command(OP_PUSH, pick_value(), 1'b0, '0);
                    send_command(OP_SEARCH, pick_value(), 1'b0, '0);
                end
                1:
                begin
                    // Drain to empty, then pop and search on the empty stack.
                    while (model_fill != 0)
                    begin
                        if ($urandom_range(0, 4) == 0)
                            send_command(OP_SEARCH, pick_value(), 1'b0, '0);
                        else
                            send_command(OP_POP, $urandom(), 1'b0, '0);
                    end
                    repeat ($urandom_range(1, 3))
                        send_command(OP_POP, $urandom(), 1'b0, '0);
                    send_command(OP_SEARCH, pick_value(), 1'b0, '0);
                end
                default:
                begin
                    // Mixed traffic, including the odd ignored code.
                    repeat ($urandom_range(20, 60))
                    begin
                        roll = $urandom_range(0, 99);
                        if (roll < 40)
                            op = OP_PUSH;
                        else if (roll < 70)
                            op = OP_POP;
                        else if (roll < 95)
                            op = OP_SEARCH;
                        else
                            op = OP_IGNORED;
                        send_command(op, pick_value(), 1'b0, '0);
                    end
                end
            endcase
            episode++;
        end

        cmd_ch.valid <= 1'b0;

        // Wait for every outstanding response, then a little longer to catch
        // anything unsolicited.
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("covered %0d push, %0d pop, %0d search and %0d ignored commands",
                 op_tally[OP_PUSH], op_tally[OP_POP], op_tally[OP_SEARCH],
                 op_tally[OP_IGNORED]);
        $display("%0d pushes dropped when full, %0d empty reports, %0d search hits, best count %0d",
                 full_drops, empty_hits, search_hits, peak_matches);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: ready follows a stall mode that is picked anew at random
    // (always ready, coin toss, repeating byte, mostly stalled).
    // ------------------------------------------------------------------------
    initial
    begin : response_stall
        stall_mode_t mode;
        logic [7:0]  pattern;
        int unsigned phase;
        phase = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            mode    = stall_mode_t'($urandom_range(0, 3));
            pattern = 8'($urandom()) | 8'h01;
            repeat ($urandom_range(40, 300))
            begin
                @(posedge clk);
                phase++;
                case (mode)
                    RX_ALWAYS:  rsp_ch.ready <= 1'b1;
                    RX_COIN:    rsp_ch.ready <= 1'($urandom_range(0, 1));
                    RX_PATTERN: rsp_ch.ready <= pattern[phase % 8];
                    default:    rsp_ch.ready <= ($urandom_range(0, 5) == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Response checker: compare each response transaction, field by field,
    // with the oldest expectation.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : response_check
        outcome_t want;
        outcome_t got;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got.status      = status_t'(rsp_ch.status);
            got.found       = rsp_ch.found;
            got.match_count = rsp_ch.match_count;
            got.occupancy   = rsp_ch.occupancy;
            if (pending_outcomes.size() == 0)
            begin
                $display("%0t: unexpected response status %0d found %0b count %0d occ %0d",
                         $time, got.status, got.found, got.match_count, got.occupancy);
                mismatch_count++;
            end
            else
            begin
                want = pending_outcomes.pop_front();
                if (got.status !== want.status)
                begin
                    $display("%0t: status expected %0d, got %0d",
                             $time, want.status, got.status);
                    mismatch_count++;
                end
                if (got.found !== want.found)
                begin
                    $display("%0t: found expected %0b, got %0b",
                             $time, want.found, got.found);
                    mismatch_count++;
                end
                if (got.match_count !== want.match_count)
                begin
                    $display("%0t: match_count expected %0d, got %0d",
                             $time, want.match_count, got.match_count);
                    mismatch_count++;
                end
                if (got.occupancy !== want.occupancy)
                begin
                    $display("%0t: occupancy expected %0d, got %0d",
                             $time, want.occupancy, got.occupancy);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: a correct run needs well under a third of this.
    // ------------------------------------------------------------------------
    initial
    begin : watchdog
        #10_000_000;
        $display("watchdog expired with %0d responses outstanding", pending_outcomes.size());
        $display("simulation failed");
        $finish;
    end

endmodule
